// File: src/binomial_lattice_backward_pricer_assert.svh
// Assertion macros used by the lattice pricer datapath.
`ifndef BINOMIAL_LATTICE_BACKWARD_PRICER_ASSERT_SVH
`define BINOMIAL_LATTICE_BACKWARD_PRICER_ASSERT_SVH
`ifndef SYNTHESIS
`define BLBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BLBP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BLBP_ASSERT(lbl, prop, msg)
`define BLBP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: src/blbp_pkg.sv
// Shared constants, types and helpers of the lattice pricer.
package blbp_pkg;

  localparam int MAX_STEPS = 1024;
  localparam int STEP_W    = 11;
  localparam int PRICE_W   = 32;
  localparam int WEIGHT_W  = 17;
  localparam int PROD_W    = PRICE_W + WEIGHT_W;
  localparam int FRAC_W    = 16;
  localparam int DEPTH     = MAX_STEPS + 1;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CFG_IDX_W = 2;

  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TREE_STEPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_WEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_WEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT   = 2'd3;

  localparam logic [STEP_W-1:0]   RST_TREE_STEPS = 11'd1;
  localparam logic [WEIGHT_W-1:0] RST_UP_WEIGHT  = 17'd32768;
  localparam logic [WEIGHT_W-1:0] RST_DOWN_WEIGHT = 17'd32768;
  localparam logic [WEIGHT_W-1:0] RST_DISCOUNT   = 17'd65536;

  typedef struct packed {
    logic take;       // latch the node, read first child
    logic load_down;  // capture down child, read up child
    logic load_up;    // capture up child, refresh held child
    logic mul;        // weight products
    logic sum;        // saturating sum
    logic disc;       // discount product
    logic finish;     // decide, write back, present result
  } blbp_cmd_t;

  typedef struct packed {
    logic expiry;      // next node sits on the expiry layer
    logic node_first;  // latched node has zero heads
    logic out_free;    // output register can take a result
  } blbp_status_t;

  // zero acts as one step, anything above the limit as the limit
  function automatic logic [STEP_W-1:0] eff_steps(input logic [STEP_W-1:0] n);
    logic [STEP_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = STEP_W'(1);
    end else if (n > STEP_W'(MAX_STEPS)) begin
      r = STEP_W'(MAX_STEPS);
    end
    return r;
  endfunction

  function automatic logic [PRICE_W-1:0] sat_price(input logic [PROD_W-FRAC_W:0] v);
    logic [PRICE_W-1:0] r;
    r = (v > {{(PROD_W-FRAC_W+1-PRICE_W){1'b0}}, PRICE_MAX}) ? PRICE_MAX : v[PRICE_W-1:0];
    return r;
  endfunction

endpackage

// File: src/blbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module blbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/blbp_ctrl.sv
// Node sequencer: steps each node through read, multiply and write-back; expiry nodes go straight to write-back.
module blbp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  blbp_pkg::blbp_status_t sts,
  output blbp_pkg::blbp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD_A = 3'd1;
  localparam logic [2:0] S_RD_B = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_DISC = 3'd5;
  localparam logic [2:0] S_DEC  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          // expiry nodes need no children
          state_next = sts.expiry ? S_DEC : S_RD_A;
        end
      end
      S_RD_A: begin
        if (sts.node_first) begin
          cmd.load_down = 1'b1;
          state_next    = S_RD_B;
        end else begin
          cmd.load_up = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_RD_B: begin
        cmd.load_up = 1'b1;
        state_next  = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_DISC;
      end
      S_DISC: begin
        cmd.disc   = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/blbp_dp.sv
// Datapath: configuration, lattice counters, layer memory, arithmetic, output register.
`include "binomial_lattice_backward_pricer_assert.svh"

module blbp_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [blbp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [blbp_pkg::WEIGHT_W-1:0]         cfg_data,
  input  logic [blbp_pkg::PRICE_W-1:0]          intrinsic_value,
  input  logic                                  may_exercise,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [blbp_pkg::PRICE_W-1:0]          node_price,
  output logic                                  exercise_now,
  output logic [blbp_pkg::STEP_W-1:0]           step_time,
  output logic [blbp_pkg::STEP_W-1:0]           heads_count,
  output logic                                  root_done,
  input  blbp_pkg::blbp_cmd_t                   cmd,
  output blbp_pkg::blbp_status_t                sts
);

  logic [blbp_pkg::STEP_W-1:0]   tree_steps;
  logic [blbp_pkg::WEIGHT_W-1:0] up_weight;
  logic [blbp_pkg::WEIGHT_W-1:0] down_weight;
  logic [blbp_pkg::WEIGHT_W-1:0] discount_factor;
  logic [blbp_pkg::STEP_W-1:0]   steps_eff;

  logic [blbp_pkg::STEP_W-1:0]   cur_time;
  logic [blbp_pkg::STEP_W-1:0]   cur_heads;
  logic [blbp_pkg::STEP_W-1:0]   d_cur;

  logic [blbp_pkg::STEP_W-1:0]   t_q;
  logic [blbp_pkg::STEP_W-1:0]   h_q;
  logic [blbp_pkg::ADDR_W-1:0]   d_q;
  logic [blbp_pkg::PRICE_W-1:0]  intrinsic_q;
  logic                          may_q;
  logic                          expiry_q;

  logic [blbp_pkg::PRICE_W-1:0]  held_q;
  logic [blbp_pkg::PRICE_W-1:0]  up_q;
  logic [blbp_pkg::PRICE_W-1:0]  down_q;
  logic [blbp_pkg::PROD_W-1:0]   pa_q;
  logic [blbp_pkg::PROD_W-1:0]   pb_q;
  logic [blbp_pkg::PROD_W-1:0]   pc_q;
  logic [blbp_pkg::PRICE_W-1:0]  sum_q;
  logic [blbp_pkg::PROD_W-blbp_pkg::FRAC_W:0] sum_wide;
  logic [blbp_pkg::PRICE_W-1:0]  cont;
  logic [blbp_pkg::PRICE_W-1:0]  price;
  logic                          exercise;

  logic                          ram_re;
  logic [blbp_pkg::ADDR_W-1:0]   ram_raddr;
  logic [blbp_pkg::PRICE_W-1:0]  ram_rdata;

  assign steps_eff = blbp_pkg::eff_steps(tree_steps);
  assign d_cur     = cur_time - cur_heads;

  assign sts.expiry     = (cur_time == steps_eff);
  assign sts.node_first = (h_q == '0);
  assign sts.out_free   = !out_valid || !out_stall;

  // first node of a layer reads its down child, every node then its up child
  assign ram_re    = cmd.take || cmd.load_down;
  assign ram_raddr = cmd.load_down ? d_q :
                     (cur_heads == '0) ? blbp_pkg::ADDR_W'(d_cur) + blbp_pkg::ADDR_W'(1) :
                                         blbp_pkg::ADDR_W'(d_cur);

  blbp_ram #(
    .WIDTH (blbp_pkg::PRICE_W),
    .DEPTH (blbp_pkg::DEPTH)
  ) u_layer (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (d_q),
    .wdata (price),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sum_wide = {1'b0, pa_q[blbp_pkg::PROD_W-1:blbp_pkg::FRAC_W]}
                  + {1'b0, pb_q[blbp_pkg::PROD_W-1:blbp_pkg::FRAC_W]};
  assign cont     = blbp_pkg::sat_price({1'b0, pc_q[blbp_pkg::PROD_W-1:blbp_pkg::FRAC_W]});

  always_comb begin
    if (expiry_q) begin
      price    = intrinsic_q;
      exercise = 1'b1;
    end else if (may_q && (intrinsic_q >= cont)) begin
      price    = intrinsic_q;
      exercise = 1'b1;
    end else begin
      price    = cont;
      exercise = 1'b0;
    end
  end

  // configuration and lattice position
  always_ff @(posedge clk) begin
    if (rst) begin
      tree_steps      <= blbp_pkg::RST_TREE_STEPS;
      up_weight       <= blbp_pkg::RST_UP_WEIGHT;
      down_weight     <= blbp_pkg::RST_DOWN_WEIGHT;
      discount_factor <= blbp_pkg::RST_DISCOUNT;
      cur_time        <= blbp_pkg::eff_steps(blbp_pkg::RST_TREE_STEPS);
      cur_heads       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        blbp_pkg::REG_TREE_STEPS: begin
          tree_steps <= cfg_data[blbp_pkg::STEP_W-1:0];
          cur_time   <= blbp_pkg::eff_steps(cfg_data[blbp_pkg::STEP_W-1:0]);
          cur_heads  <= '0;
        end
        blbp_pkg::REG_UP_WEIGHT:   up_weight       <= cfg_data;
        blbp_pkg::REG_DOWN_WEIGHT: down_weight     <= cfg_data;
        blbp_pkg::REG_DISCOUNT:    discount_factor <= cfg_data;
        default: begin
        end
      endcase
    end else if (cmd.take) begin
      // advance to the next node; wrap to a new tree after the root
      if (cur_heads >= cur_time) begin
        cur_time  <= (cur_time == '0) ? steps_eff : cur_time - blbp_pkg::STEP_W'(1);
        cur_heads <= '0;
      end else begin
        cur_heads <= cur_heads + blbp_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_q <= '0;
    end else if (cmd.load_up) begin
      held_q <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      t_q         <= cur_time;
      h_q         <= cur_heads;
      d_q         <= blbp_pkg::ADDR_W'(d_cur);
      intrinsic_q <= intrinsic_value;
      may_q       <= may_exercise;
      expiry_q    <= sts.expiry;
    end
    if (cmd.load_down) begin
      down_q <= ram_rdata;
    end
    if (cmd.load_up) begin
      up_q <= ram_rdata;
      // later nodes of a layer take the value the previous node overwrote
      if (h_q != '0) begin
        down_q <= held_q;
      end
    end
    if (cmd.mul) begin
      pa_q <= up_weight * up_q;
      pb_q <= down_weight * down_q;
    end
    if (cmd.sum) begin
      sum_q <= blbp_pkg::sat_price(sum_wide);
    end
    if (cmd.disc) begin
      pc_q <= discount_factor * sum_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      node_price   <= price;
      exercise_now <= exercise;
      step_time    <= t_q;
      heads_count  <= h_q;
      root_done    <= (t_q == '0);
    end
  end

  `BLBP_ASSERT(a_finish_shows_beat, cmd.finish |=> out_valid, "finish did not present a beat")
  `BLBP_ASSERT_NEVER(a_heads_in_layer, cur_heads > cur_time, "heads count ran past its layer")
  `BLBP_ASSERT_NEVER(a_time_in_tree, cur_time > steps_eff, "time layer ran past the tree")
  `BLBP_ASSERT_NEVER(a_out_heads_in_layer, out_valid && (heads_count > step_time),
                     "result beat carries heads beyond its layer")

endmodule

// File: src/binomial_lattice_backward_pricer.sv
// Top level of the binomial lattice backward pricer.
//
// Feed nodes on the input channel (in_valid / in_stall) layer by layer from
// expiry down to time 0, ascending heads within a layer. Each beat carries
// intrinsic_value and may_exercise; one result beat (node_price,
// exercise_now, step_time, heads_count, root_done) leaves on the output
// channel (out_valid / out_stall) per node, in order.
// One node is in work at a time. An expiry-layer node is taken and goes
// straight to its write-back; an interior node first passes the layer
// memory reads (one port, registered; one more for the first node of an
// interior layer), then the weight products, the saturating sum, the discount
// product and the write-back, which also loads the result into the output register.
// A finished result waits there while out_stall is high; the next node is
// already accepted and runs up to its write-back, which holds until the beat
// leaves. Reset loads the register defaults (one step, p = q = 0.5,
// discount 1.0) and starts at the expiry layer; the layer memory needs no
// clearing. The user makes configuration writes only while no node is in
// work (unenforced); a tree_steps write restarts the tree at its expiry layer.
module binomial_lattice_backward_pricer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [blbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blbp_pkg::WEIGHT_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [blbp_pkg::PRICE_W-1:0]   intrinsic_value,
  input  logic                           may_exercise,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [blbp_pkg::PRICE_W-1:0]   node_price,
  output logic                           exercise_now,
  output logic [blbp_pkg::STEP_W-1:0]    step_time,
  output logic [blbp_pkg::STEP_W-1:0]    heads_count,
  output logic                           root_done
);

  blbp_pkg::blbp_cmd_t    cmd;
  blbp_pkg::blbp_status_t sts;

  blbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  blbp_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .intrinsic_value (intrinsic_value),
    .may_exercise    (may_exercise),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .node_price      (node_price),
    .exercise_now    (exercise_now),
    .step_time       (step_time),
    .heads_count     (heads_count),
    .root_done       (root_done),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// File: bench/binomial_lattice_backward_pricer_test.sv
// Self-checking testbench for the binomial lattice backward pricer.
module binomial_lattice_backward_pricer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_TARGET = 650;

  typedef struct packed {
    logic [blbp_pkg::PRICE_W-1:0] value;
    logic                         may;
  } node_in_t;

  typedef struct packed {
    logic [blbp_pkg::PRICE_W-1:0] price;
    logic                         exercise;
    logic [blbp_pkg::STEP_W-1:0]  t;
    logic [blbp_pkg::STEP_W-1:0]  h;
    logic                         root;
  } node_out_t;

  typedef enum {VAL_FULL, VAL_COARSE, VAL_EXTREME, VAL_MODEST} value_style_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [blbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [blbp_pkg::WEIGHT_W-1:0]  cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [blbp_pkg::PRICE_W-1:0]   intrinsic_value = '0;
  logic                           may_exercise = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [blbp_pkg::PRICE_W-1:0]   node_price;
  logic                           exercise_now;
  logic [blbp_pkg::STEP_W-1:0]    step_time;
  logic [blbp_pkg::STEP_W-1:0]    heads_count;
  logic                           root_done;

  binomial_lattice_backward_pricer uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .intrinsic_value(intrinsic_value),
    .may_exercise(may_exercise),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .node_price(node_price),
    .exercise_now(exercise_now),
    .step_time(step_time),
    .heads_count(heads_count),
    .root_done(root_done)
  );

  initial forever #5 clk = ~clk;

  // lattice mirror: one layer of prices plus sequencing and registers
  logic [blbp_pkg::PRICE_W-1:0]  lat_price [0:blbp_pkg::MAX_STEPS];
  logic [blbp_pkg::PRICE_W-1:0]  held_price;
  logic [blbp_pkg::STEP_W-1:0]   at_time;
  logic [blbp_pkg::STEP_W-1:0]   at_heads;
  logic [blbp_pkg::STEP_W-1:0]   m_steps;
  logic [blbp_pkg::WEIGHT_W-1:0] m_up;
  logic [blbp_pkg::WEIGHT_W-1:0] m_down;
  logic [blbp_pkg::WEIGHT_W-1:0] m_disc;

  node_in_t  node_q [$];
  node_out_t priced_q [$];

  int nodes_queued = 0;
  int nodes_accepted = 0;
  int results_seen = 0;
  int roots_seen = 0;
  int exercise_seen = 0;
  int settings_used = 1;
  int failures = 0;

  function automatic logic [blbp_pkg::STEP_W-1:0] clamp_steps(
      input logic [blbp_pkg::STEP_W-1:0] n);
    if (n == '0) return blbp_pkg::STEP_W'(1);
    if (n > blbp_pkg::STEP_W'(blbp_pkg::MAX_STEPS)) return blbp_pkg::STEP_W'(blbp_pkg::MAX_STEPS);
    return n;
  endfunction

  function automatic logic [blbp_pkg::PRICE_W-1:0] cap_price(input logic [63:0] v);
    return (v > 64'(blbp_pkg::PRICE_MAX)) ? blbp_pkg::PRICE_MAX : v[blbp_pkg::PRICE_W-1:0];
  endfunction

  // value one node, overwrite its slot in the layer, advance to the next node
  function automatic node_out_t price_node(input logic [blbp_pkg::PRICE_W-1:0] value,
                                           input logic may);
    node_out_t                    r;
    logic [blbp_pkg::STEP_W-1:0]  n, t, h, d;
    logic [blbp_pkg::PRICE_W-1:0] up_child, down_child, cont;
    logic [63:0]                  a, b;
    n = clamp_steps(m_steps);
    t = (at_time > n) ? n : at_time;
    h = (at_heads > t) ? t : at_heads;
    d = t - h;
    r.t = t;
    r.h = h;
    r.root = (t == '0);
    if (t >= n) begin
      r.price = value;
      r.exercise = 1'b1;
    end else begin
      down_child = (h == '0) ? lat_price[d + blbp_pkg::STEP_W'(1)] : held_price;
      up_child = lat_price[d];
      a = (64'(m_up) * 64'(up_child)) >> blbp_pkg::FRAC_W;
      b = (64'(m_down) * 64'(down_child)) >> blbp_pkg::FRAC_W;
      cont = cap_price((64'(m_disc) * 64'(cap_price(a + b))) >> blbp_pkg::FRAC_W);
      if (may && value >= cont) begin
        r.price = value;
        r.exercise = 1'b1;
      end else begin
        r.price = cont;
        r.exercise = 1'b0;
      end
    end
    held_price = lat_price[d];
    lat_price[d] = r.price;
    if (h >= t) begin
      at_time = (t == '0) ? n : t - 1'b1;
      at_heads = '0;
    end else begin
      at_time = t;
      at_heads = h + 1'b1;
    end
    return r;
  endfunction

  // driver: bursts of beats with random gaps, mirror updated on each accept
  int       burst_left = 0;
  int       gap_left = 0;
  node_in_t next_node;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_steps = blbp_pkg::RST_TREE_STEPS;
      m_up = blbp_pkg::RST_UP_WEIGHT;
      m_down = blbp_pkg::RST_DOWN_WEIGHT;
      m_disc = blbp_pkg::RST_DISCOUNT;
      held_price = '0;
      at_time = clamp_steps(blbp_pkg::RST_TREE_STEPS);
      at_heads = '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          blbp_pkg::REG_TREE_STEPS: begin
            m_steps = cfg_data[blbp_pkg::STEP_W-1:0];
            at_time = clamp_steps(m_steps);
            at_heads = '0;
          end
          blbp_pkg::REG_UP_WEIGHT:   m_up = cfg_data;
          blbp_pkg::REG_DOWN_WEIGHT: m_down = cfg_data;
          blbp_pkg::REG_DISCOUNT:    m_disc = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        priced_q.push_back(price_node(intrinsic_value, may_exercise));
        nodes_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (node_q.size() > 0) begin
          next_node = node_q.pop_front();
          in_valid <= 1'b1;
          intrinsic_value <= next_node.value;
          may_exercise <= next_node.may;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
              0, 1: gap_left = 0;
              2: gap_left = $urandom_range(1, 4);
              default: gap_left = $urandom_range(5, 20);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] expv,
                             input logic [63:0] actv);
    if (expv !== actv) begin
      failures++;
      $display("%0t: %s mismatch on beat %0d: expected %0h, actual %0h",
               $time, name, results_seen, expv, actv);
    end
  endtask

  // monitor: check each result beat, drive out_stall on its own pattern
  int          cycle_cnt = 0;
  int          hold_left = 0;
  int          next_hold_at = 150;
  stall_mode_t stall_mode = STALL_NONE;
  node_out_t   want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (priced_q.size() == 0) begin
          failures++;
          $display("%0t: result beat with nothing expected: price %0h time %0d heads %0d",
                   $time, node_price, step_time, heads_count);
        end else begin
          want = priced_q.pop_front();
          check_field("node_price", 64'(want.price), 64'(node_price));
          check_field("exercise_now", 64'(want.exercise), 64'(exercise_now));
          check_field("step_time", 64'(want.t), 64'(step_time));
          check_field("heads_count", 64'(want.h), 64'(heads_count));
          check_field("root_done", 64'(want.root), 64'(root_done));
          results_seen++;
          if (want.root) roots_seen++;
          if (want.exercise) exercise_seen++;
        end
      end
      cycle_cnt++;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (results_seen >= next_hold_at && node_q.size() > 4) begin
        // long hold-off while beats are still pending: back up into the input
        out_stall <= 1'b1;
        hold_left = 119;
        next_hold_at += 300;
      end else begin
        if (cycle_cnt % 97 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= (cycle_cnt % 4 == 3);
        endcase
      end
    end
  end

  function automatic logic [blbp_pkg::PRICE_W-1:0] pick_value(input value_style_t s);
    case (s)
      VAL_FULL:   return $urandom;
      VAL_COARSE: return blbp_pkg::PRICE_W'($urandom_range(0, 6)) * 32'h8000;
      VAL_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return blbp_pkg::PRICE_MAX;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  function automatic logic [blbp_pkg::WEIGHT_W-1:0] extreme_weight();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return blbp_pkg::WEIGHT_W'(1);
      2: return blbp_pkg::WEIGHT_W'(65536);
      default: return '1;
    endcase
  endfunction

  task automatic queue_node(input logic [blbp_pkg::PRICE_W-1:0] value, input logic may);
    node_in_t nd;
    nd.value = value;
    nd.may = may;
    node_q.push_back(nd);
    nodes_queued++;
  endtask

  task automatic queue_random(input int count, input value_style_t bias);
    value_style_t s;
    for (int i = 0; i < count; i++) begin
      s = ($urandom_range(0, 3) == 0) ? value_style_t'($urandom_range(0, 3)) : bias;
      queue_node(pick_value(s), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic write_reg(input logic [blbp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [blbp_pkg::WEIGHT_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic program_lattice(input logic do_steps,
                                 input logic [blbp_pkg::WEIGHT_W-1:0] steps,
                                 input logic [blbp_pkg::WEIGHT_W-1:0] up,
                                 input logic [blbp_pkg::WEIGHT_W-1:0] down,
                                 input logic [blbp_pkg::WEIGHT_W-1:0] disc);
    if (do_steps) write_reg(blbp_pkg::REG_TREE_STEPS, steps);
    write_reg(blbp_pkg::REG_UP_WEIGHT, up);
    write_reg(blbp_pkg::REG_DOWN_WEIGHT, down);
    write_reg(blbp_pkg::REG_DISCOUNT, disc);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // wait until every queued node has been priced and its beat checked
  task automatic wait_idle();
    do @(posedge clk); while (nodes_accepted != nodes_queued || priced_q.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    int                            r, n, count;
    logic [blbp_pkg::WEIGHT_W-1:0] steps, up, down, disc;
    logic                          keep_tree;
    value_style_t                  bias;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one step, even weights, no discount
    queue_node(32'd100, 1'b1);
    queue_node(32'd100, 1'b0);
    queue_node(32'd100, 1'b1);   // intrinsic ties the continuation
    queue_node(blbp_pkg::PRICE_MAX, 1'b1);
    queue_node(blbp_pkg::PRICE_MAX, 1'b1);
    queue_node(32'd0, 1'b0);
    queue_node(32'd0, 1'b0);
    queue_node(32'd0, 1'b1);
    queue_node(blbp_pkg::PRICE_MAX, 1'b1);
    wait_idle();

    // weights and discount above one: sum and product saturate
    program_lattice(1'b1, 17'd2, '1, '1, '1);
    queue_node(blbp_pkg::PRICE_MAX, 1'b0);
    queue_node(32'h8000_0000, 1'b1);
    queue_node(32'd1, 1'b0);
    queue_node(32'd5, 1'b0);
    queue_node(32'd5, 1'b1);
    queue_node(blbp_pkg::PRICE_MAX, 1'b1);
    wait_idle();

    // zero steps acts as one; zero discount gives a zero continuation
    program_lattice(1'b1, 17'd0, 17'd0, 17'd65536, 17'd0);
    queue_node(32'h1234_5678, 1'b1);
    queue_node(32'hFFFF_0000, 1'b1);
    queue_node(32'd0, 1'b1);
    wait_idle();

    // step count above the limit acts as the limit
    program_lattice(1'b1, 17'h007FF, 17'd65536, 17'd0, 17'd65536);
    repeat (4) queue_node($urandom, 1'($urandom_range(0, 1)));
    wait_idle();

    // upper data bits beyond the step field are dropped
    program_lattice(1'b1, 17'h1F803, 17'd40000, 17'd25536, 17'd60000);
    queue_node(32'h0003_0000, 1'b0);
    queue_node(32'h0001_0000, 1'b1);
    queue_node(32'h0000_8000, 1'b0);
    wait_idle();

    while (nodes_queued < NODE_TARGET) begin
      keep_tree = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 19);
      if (r < 14) steps = blbp_pkg::WEIGHT_W'($urandom_range(1, 5));
      else if (r < 17) steps = blbp_pkg::WEIGHT_W'($urandom_range(6, 10));
      else if (r < 18) steps = blbp_pkg::WEIGHT_W'(blbp_pkg::MAX_STEPS);
      else if (r < 19) steps = 17'h007FF;
      else steps = '0;
      r = $urandom_range(0, 3);
      if (r == 0) begin
        up = blbp_pkg::WEIGHT_W'($urandom_range(0, 65536));
        down = 17'd65536 - up;
        disc = blbp_pkg::WEIGHT_W'($urandom_range(52000, 65536));
        bias = VAL_MODEST;
      end else if (r == 1) begin
        up = 17'd32768;
        down = 17'd32768;
        disc = 17'd65536;
        bias = VAL_COARSE;   // coarse values make ties likely
      end else if (r == 2) begin
        up = blbp_pkg::WEIGHT_W'($urandom_range(0, 17'h1FFFF));
        down = blbp_pkg::WEIGHT_W'($urandom_range(0, 17'h1FFFF));
        disc = blbp_pkg::WEIGHT_W'($urandom_range(0, 17'h1FFFF));
        bias = VAL_FULL;
      end else begin
        up = extreme_weight();
        down = extreme_weight();
        disc = extreme_weight();
        bias = VAL_EXTREME;
      end
      n = int'(clamp_steps(steps[blbp_pkg::STEP_W-1:0]));
      if (n >= blbp_pkg::MAX_STEPS) count = $urandom_range(4, 30);
      else count = $urandom_range(1, 3) * (n + 1) * (n + 2) / 2 + $urandom_range(0, n);
      if (count > NODE_TARGET - nodes_queued) count = NODE_TARGET - nodes_queued;
      program_lattice(!keep_tree, steps, up, down, disc);
      queue_random(count, bias);
      wait_idle();
    end

    $display("Checked %0d priced nodes over %0d register settings, with long output hold-offs.",
             results_seen, settings_used);
    $display("%0d trees reached their root; %0d nodes chose exercise.", roots_seen, exercise_seen);
    if (failures == 0 && priced_q.size() == 0) begin
      $display("binomial_lattice_backward_pricer verification clean");
    end else begin
      $display("binomial_lattice_backward_pricer verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("binomial_lattice_backward_pricer verification failed");
    $finish;
  end

endmodule
